[hw/rtl/codebook_delay_skew_top_macros.svh]
// assertion macros for the codebook delay skew block
// used by the checker module only, no other dependencies
`ifndef CODEBOOK_DELAY_SKEW_TOP_MACROS_SVH
`define CODEBOOK_DELAY_SKEW_TOP_MACROS_SVH

// same-cycle implication on the rising clock, quiet during reset
`define CDS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication on the rising clock, quiet during reset
`define CDS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[hw/rtl/cds_pkg.sv]
// shared types and constants of the codebook delay skew block
// no dependencies
package cds_pkg;

   localparam int NUM_SLOTS = 8;   // codebook slots on the ports
   localparam int IN_BITS   = 10;  // width of one input code
   localparam int OUT_BITS  = 11;  // width of one output slot

   localparam logic [OUT_BITS-1:0] BEGIN_MARK = 11'd1024;
   localparam logic [OUT_BITS-1:0] END_MARK   = 11'd1025;

   typedef logic [NUM_SLOTS-1:0][OUT_BITS-1:0] slot_vec_type;

   typedef struct packed {
      logic         out_last;
      slot_vec_type slots;
   } rsp_frame_type;

endpackage

[hw/rtl/cds_req_if.sv]
// request channel of the codebook delay skew block
// depends on cds_pkg for field widths
interface cds_req_if;
   logic                        valid;
   logic                        ready;
   logic [cds_pkg::IN_BITS-1:0] code_0;
   logic [cds_pkg::IN_BITS-1:0] code_1;
   logic [cds_pkg::IN_BITS-1:0] code_2;
   logic [cds_pkg::IN_BITS-1:0] code_3;
   logic [cds_pkg::IN_BITS-1:0] code_4;
   logic [cds_pkg::IN_BITS-1:0] code_5;
   logic [cds_pkg::IN_BITS-1:0] code_6;
   logic [cds_pkg::IN_BITS-1:0] code_7;
   logic                        last_frame;

   modport source (output valid, code_0, code_1, code_2, code_3, code_4, code_5, code_6,
                   code_7, last_frame, input ready);
   modport sink   (input valid, code_0, code_1, code_2, code_3, code_4, code_5, code_6,
                   code_7, last_frame, output ready);
   modport mon    (input valid, ready, code_0, code_1, code_2, code_3, code_4, code_5,
                   code_6, code_7, last_frame);
endinterface

[hw/rtl/cds_rsp_if.sv]
// response channel of the codebook delay skew block
// depends on cds_pkg for field widths
interface cds_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cds_pkg::OUT_BITS-1:0] out_0;
   logic [cds_pkg::OUT_BITS-1:0] out_1;
   logic [cds_pkg::OUT_BITS-1:0] out_2;
   logic [cds_pkg::OUT_BITS-1:0] out_3;
   logic [cds_pkg::OUT_BITS-1:0] out_4;
   logic [cds_pkg::OUT_BITS-1:0] out_5;
   logic [cds_pkg::OUT_BITS-1:0] out_6;
   logic [cds_pkg::OUT_BITS-1:0] out_7;
   logic                         out_last;

   modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                   out_last, input ready);
   modport sink   (input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                   out_last, output ready);
   modport mon    (input valid, ready, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
                   out_7, out_last);
endinterface

[hw/rtl/cds_out_buf.sv]
// two-entry output buffer (main register plus skid register) for response frames
// depends on cds_pkg for the frame type
module cds_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cds_pkg::rsp_frame_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cds_pkg::rsp_frame_type out_data
);

   logic                   main_valid_ff, main_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   cds_pkg::rsp_frame_type main_ff, main_in;
   cds_pkg::rsp_frame_type skid_ff, skid_in;
   logic                   push;
   logic                   pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // skid drains into main, no push possible here
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

[hw/rtl/codebook_delay_skew_top.sv]
// channel  | dir | handshake        | payload
// req_ch   | in  | valid and ready  | code_0..code_7 (10 bit), last_frame
// rsp_ch   | out | valid and ready  | out_0..out_7 (11 bit), out_last
//
// one response frame per request, one request per cycle when rsp_ch keeps up
// a request with last_frame set adds NUM_CODEBOOKS-1 flush frames, one per cycle when rsp_ch keeps up,
// set by the flush counter; req_ch.ready is low while they are produced
// synchronous active-high reset clears the frame count and flush control;
// the delay lines hold no reset value and are guarded by the frame count
// the two-entry output buffer keeps req_ch.ready independent of rsp_ch.ready
//
// delay-pattern skew of audio-token frames; depends on cds_pkg, cds_req_if,
// cds_rsp_if and cds_out_buf
module codebook_delay_skew_top #(
   parameter int NUM_CODEBOOKS = 8,
   parameter int CODE_BITS     = 10
) (
   input  logic      clock,
   input  logic      reset,
   cds_req_if.sink   req_ch,
   cds_rsp_if.source rsp_ch
);

   // codes wider than the input field carry no more information
   localparam int HIST_BITS = (CODE_BITS < cds_pkg::IN_BITS) ? CODE_BITS : cds_pkg::IN_BITS;
   // flush index of the final flush frame
   localparam logic [2:0] LAST_FLUSH = 3'(NUM_CODEBOOKS - 1);
   localparam logic       SINGLE_BOOK = (NUM_CODEBOOKS == 1);

   // control state
   logic [2:0] frames_ff, frames_in;   // frames of this sequence, saturating at 7
   logic       flush_ff, flush_in;     // flush frames in progress
   logic [2:0] step_ff, step_in;       // index of the flush frame being produced

   logic [cds_pkg::NUM_SLOTS-1:0][cds_pkg::IN_BITS-1:0] req_code;
   cds_pkg::slot_vec_type  slot_val;
   cds_pkg::rsp_frame_type gen_frame;
   cds_pkg::rsp_frame_type buf_frame;
   logic                   buf_ready;
   logic                   req_acc;
   logic                   flush_step;

   assign req_code[0] = req_ch.code_0;
   assign req_code[1] = req_ch.code_1;
   assign req_code[2] = req_ch.code_2;
   assign req_code[3] = req_ch.code_3;
   assign req_code[4] = req_ch.code_4;
   assign req_code[5] = req_ch.code_5;
   assign req_code[6] = req_ch.code_6;
   assign req_code[7] = req_ch.code_7;

   // requests are blocked while flush frames go out
   assign req_ch.ready = buf_ready && !flush_ff;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign flush_step   = flush_ff && buf_ready;

   // per-codebook delay lines and slot selection
   for (genvar c = 0; c < cds_pkg::NUM_SLOTS; c++) begin : g_slot
      if (c >= NUM_CODEBOOKS) begin : g_unused
         assign slot_val[c] = '0;
      end else if (c == 0) begin : g_direct
         // codebook 0 passes straight through; every flush frame ends it
         assign slot_val[c] = flush_ff ? cds_pkg::END_MARK
                                       : cds_pkg::OUT_BITS'(req_code[c][HIST_BITS-1:0]);
      end else begin : g_delay
         // entry e holds the code of the frame e+1 requests back
         logic [HIST_BITS-1:0] line_ff [c];
         logic [2:0]           back;
         logic [HIST_BITS-1:0] picked;
         logic [cds_pkg::OUT_BITS-1:0] regular_val;
         logic [cds_pkg::OUT_BITS-1:0] flush_val;

         always_ff @(posedge clock) begin
            if (req_acc) begin
               line_ff[0] <= req_code[c][HIST_BITS-1:0];
               for (int e = 1; e < c; e++) begin
                  line_ff[e] <= line_ff[e-1];
               end
            end
         end

         // regular frame: oldest entry once c frames have been seen
         assign regular_val = (frames_ff >= 3'(c)) ? cds_pkg::OUT_BITS'(line_ff[c-1])
                                                   : cds_pkg::BEGIN_MARK;

         // flush frame k: entry c-k, end marker for codebooks below k
         assign back = 3'(c) - step_ff;

         always_comb begin
            picked = '0;
            for (int e = 0; e < c; e++) begin
               if (back == 3'(e)) begin
                  picked = line_ff[e];
               end
            end
         end

         assign flush_val = (3'(c) < step_ff) ? cds_pkg::END_MARK
                          : (frames_ff > back) ? cds_pkg::OUT_BITS'(picked)
                          : cds_pkg::BEGIN_MARK;

         assign slot_val[c] = flush_ff ? flush_val : regular_val;
      end
   end

   assign gen_frame.slots    = slot_val;
   assign gen_frame.out_last = flush_ff ? (step_ff == LAST_FLUSH)
                                        : (SINGLE_BOOK && req_ch.last_frame);

   // control next state
   always_comb begin
      frames_in = frames_ff;
      flush_in  = flush_ff;
      step_in   = step_ff;
      if (flush_step) begin
         if (step_ff == LAST_FLUSH) begin
            // sequence done, start over
            flush_in  = 1'b0;
            frames_in = '0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end else if (req_acc) begin
         if (req_ch.last_frame && SINGLE_BOOK) begin
            frames_in = '0;
         end else begin
            frames_in = (frames_ff == 3'd7) ? frames_ff : frames_ff + 3'd1;
            if (req_ch.last_frame) begin
               flush_in = 1'b1;
               step_in  = 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= '0;
         flush_ff  <= 1'b0;
         step_ff   <= '0;
      end else begin
         frames_ff <= frames_in;
         flush_ff  <= flush_in;
         step_ff   <= step_in;
      end
   end

   // output buffer, loaded by a request or a flush step
   cds_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (flush_ff || req_ch.valid),
      .in_ready  (buf_ready),
      .in_data   (gen_frame),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (buf_frame)
   );

   assign rsp_ch.out_0    = buf_frame.slots[0];
   assign rsp_ch.out_1    = buf_frame.slots[1];
   assign rsp_ch.out_2    = buf_frame.slots[2];
   assign rsp_ch.out_3    = buf_frame.slots[3];
   assign rsp_ch.out_4    = buf_frame.slots[4];
   assign rsp_ch.out_5    = buf_frame.slots[5];
   assign rsp_ch.out_6    = buf_frame.slots[6];
   assign rsp_ch.out_7    = buf_frame.slots[7];
   assign rsp_ch.out_last = buf_frame.out_last;

endmodule

[hw/rtl/cds_checker.sv]
// port-level checks of the codebook delay skew block, bound to the top level
// depends on cds_pkg and the macro header
`include "codebook_delay_skew_top_macros.svh"

module cds_checker #(
   parameter int NUM_CODEBOOKS = 8
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_last,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_last,
   input logic [cds_pkg::OUT_BITS-1:0] rsp_out_0,
   input logic [cds_pkg::OUT_BITS-1:0] rsp_out_7
);

   localparam logic MULTI_BOOK = (NUM_CODEBOOKS > 1);
   localparam logic SPARE_SLOT = (NUM_CODEBOOKS < cds_pkg::NUM_SLOTS);

   // a stalled response stays offered
   `CDS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // a final request starts a flush that blocks the next request
   `CDS_ASSERT_NEXT(a_flush_blocks, MULTI_BOOK && req_valid && req_ready && req_last, !req_ready)

   // the closing flush frame has ended codebook 0
   `CDS_ASSERT_NOW(a_last_ends, MULTI_BOOK && rsp_valid && rsp_last, rsp_out_0 == cds_pkg::END_MARK)

   // slots beyond the configured codebooks stay zero
   `CDS_ASSERT_NOW(a_spare_zero, SPARE_SLOT && rsp_valid, rsp_out_7 == '0)

endmodule

bind codebook_delay_skew_top cds_checker #(.NUM_CODEBOOKS(NUM_CODEBOOKS)) u_cds_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_last  (req_ch.last_frame),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_last  (rsp_ch.out_last),
   .rsp_out_0 (rsp_ch.out_0),
   .rsp_out_7 (rsp_ch.out_7)
);
